>>> rtl/btcp_pkg.sv
// ----------------------------------------------------------------------------
// btcp_pkg: shared types and constants for the binomial call pricer
// Word widths, CSR indexes, reset values, sequencer states and the request
// and result structs of the shared multiply-add unit.
// ----------------------------------------------------------------------------
package btcp_pkg;

   localparam int DATA_W        = 32;
   localparam int STEPS_W       = 11;
   localparam int CSR_IDX_W     = 3;
   localparam int MAX_STEPS_DEF = 1024;

   localparam logic [STEPS_W-1:0] NUM_STEPS_RST = STEPS_W'(64);
   localparam logic [DATA_W-1:0]  ONE_Q30_RST   = 32'h4000_0000;
   localparam logic [DATA_W-1:0]  HALF_Q31_RST  = 32'h4000_0000;
   localparam logic [DATA_W-1:0]  SAT_VALUE     = 32'hFFFF_FFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_STEPS      = 3'd0,
      CSR_UP_SQUARED     = 3'd1,
      CSR_LOWEST_FACTOR  = 3'd2,
      CSR_DISC_UP_PROB   = 3'd3,
      CSR_DISC_DOWN_PROB = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LEAF_ISSUE,
      ST_LEAF_WAIT,
      ST_FOLD_LOAD,
      ST_FOLD_RUN,
      ST_FOLD_DRAIN,
      ST_DONE
   } state_type;

   // Leaf: Q16.16 x Q2.30, round and shift by 30.
   // Fold: two Q16.16 x Q1.31 products summed, round and shift by 31.
   typedef enum logic {
      MAC_LEAF,
      MAC_FOLD
   } mac_op_type;

   typedef struct packed {
      logic              valid;
      mac_op_type        op;
      logic [DATA_W-1:0] a0;
      logic [DATA_W-1:0] b0;
      logic [DATA_W-1:0] a1;
      logic [DATA_W-1:0] b1;
   } mac_req_type;

   typedef struct packed {
      logic              valid;
      logic              sat;
      logic [DATA_W-1:0] value;
   } mac_res_type;

endpackage

>>> rtl/btcp_if.sv
// ----------------------------------------------------------------------------
// btcp_if: valid/ready channels of the binomial call pricer
// Request word carries spot and strike; response word carries the root value
// and the saturation flag.
// ----------------------------------------------------------------------------
interface btcp_req_if;
   logic                      valid;
   logic                      ready;
   logic [btcp_pkg::DATA_W-1:0] spot_price;
   logic [btcp_pkg::DATA_W-1:0] strike_price;

   modport source (output valid, output spot_price, output strike_price, input ready);
   modport sink   (input valid, input spot_price, input strike_price, output ready);
endinterface

interface btcp_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [btcp_pkg::DATA_W-1:0] option_value;
   logic                      saturated;

   modport source (output valid, output option_value, output saturated, input ready);
   modport sink   (input valid, input option_value, input saturated, output ready);
endinterface

>>> rtl/binomial_tree_call_pricer.sv
// Sequence: with N being num_steps clamped to MAX_STEPS, the leaves run one at a time
//   through the two-stage unit, then each fold level runs one node per cycle between a load
//   and a drain, and then the root is posted.
// A new request word is taken only in idle, once the last result is posted; ready returns in
//   the same cycle as the result is posted, later while a stalled result word holds the done state.
// Reset: synchronous, active high; clears control and loads CSR reset values.
// ----------------------------------------------------------------------------
// binomial_tree_call_pricer: European call on a recombining binomial tree
// A small sequencer drives one shared multiply-add unit and one node RAM:
// first the leaf prices by repeated multiplication, then N fold levels.
// ----------------------------------------------------------------------------
module binomial_tree_call_pricer #(
   parameter int MAX_STEPS = btcp_pkg::MAX_STEPS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   btcp_req_if.sink                       req_ch,
   btcp_rsp_if.source                     rsp_ch,
   input  logic                           csr_write_en,
   input  logic [btcp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [btcp_pkg::DATA_W-1:0]    csr_write_data
);

   localparam int DEPTH = MAX_STEPS + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = (AW > btcp_pkg::STEPS_W) ? AW : btcp_pkg::STEPS_W;
   localparam int DW    = btcp_pkg::DATA_W;

   // ---------------------------------------------------------------- CSRs
   logic [btcp_pkg::STEPS_W-1:0] num_steps_ff;
   logic [DW-1:0]                up_squared_ff;
   logic [DW-1:0]                lowest_factor_ff;
   logic [DW-1:0]                disc_up_prob_ff;
   logic [DW-1:0]                disc_down_prob_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_steps_ff      <= btcp_pkg::NUM_STEPS_RST;
         up_squared_ff     <= btcp_pkg::ONE_Q30_RST;
         lowest_factor_ff  <= btcp_pkg::ONE_Q30_RST;
         disc_up_prob_ff   <= btcp_pkg::HALF_Q31_RST;
         disc_down_prob_ff <= btcp_pkg::HALF_Q31_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            btcp_pkg::CSR_NUM_STEPS: begin
               num_steps_ff <= csr_write_data[btcp_pkg::STEPS_W-1:0];
            end
            btcp_pkg::CSR_UP_SQUARED:     up_squared_ff     <= csr_write_data;
            btcp_pkg::CSR_LOWEST_FACTOR:  lowest_factor_ff  <= csr_write_data;
            btcp_pkg::CSR_DISC_UP_PROB:   disc_up_prob_ff   <= csr_write_data;
            btcp_pkg::CSR_DISC_DOWN_PROB: disc_down_prob_ff <= csr_write_data;
            default: ; // drop writes to unused indexes
         endcase
      end
   end

   // ---------------------------------------------------------------- state
   btcp_pkg::state_type state_ff, state_in;

   logic [DW-1:0] spot_ff,      spot_in;
   logic [DW-1:0] strike_ff,    strike_in;
   logic [AW-1:0] n_ff,         n_in;       // clamped step count
   logic [AW-1:0] idx_ff,       idx_in;     // leaf index, then read index
   logic [AW-1:0] level_ff,     level_in;   // current fold level
   logic [DW-1:0] asset_ff,     asset_in;   // running leaf asset price
   logic          asset_sat_ff, asset_sat_in;
   logic          sat_ff,       sat_in;
   logic [DW-1:0] lower_ff,     lower_in;   // C[j] held for the next node
   logic          rd_valid_ff,  rd_valid_in;
   logic [AW-1:0] rd_addr_ff,   rd_addr_in;
   logic [DW-1:0] root_ff,      root_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_value_ff, rsp_value_in;
   logic          rsp_sat_ff,   rsp_sat_in;

   // ---------------------------------------------------------------- datapath nets
   btcp_pkg::mac_req_type mac_req;
   btcp_pkg::mac_res_type mac_res;
   logic [AW-1:0]         mac_tag_in;
   logic [AW-1:0]         mac_tag_out;
   logic                  mac_busy;

   logic                  ram_we;
   logic [DW-1:0]         ram_wdata;
   logic                  ram_re;
   logic [AW-1:0]         ram_raddr;
   logic [DW-1:0]         ram_rdata;

   logic                  req_accept;
   logic                  rsp_free;
   logic [CW-1:0]         steps_wide;
   logic [AW-1:0]         steps_clamped;
   logic                  leaf_sat;
   logic [DW-1:0]         leaf_value;
   logic                  drained;

   assign req_accept = req_ch.valid && req_ch.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign drained    = !rd_valid_ff && !mac_busy;

   // Clamp the step count to what the node RAM holds
   assign steps_wide    = CW'(num_steps_ff);
   assign steps_clamped = (steps_wide > CW'(MAX_STEPS)) ? AW'(MAX_STEPS) : AW'(steps_wide);

   // Leaf payoff: once an asset price saturates, every higher leaf saturates too
   assign leaf_sat   = asset_sat_ff | mac_res.sat;
   assign leaf_value = leaf_sat ? btcp_pkg::SAT_VALUE :
                       (mac_res.value > strike_ff) ? (mac_res.value - strike_ff) : '0;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         btcp_pkg::ST_IDLE: begin
            if (req_accept) state_in = btcp_pkg::ST_LEAF_ISSUE;
         end
         btcp_pkg::ST_LEAF_ISSUE: state_in = btcp_pkg::ST_LEAF_WAIT;
         btcp_pkg::ST_LEAF_WAIT: begin
            if (mac_res.valid) begin
               if (idx_ff != n_ff)  state_in = btcp_pkg::ST_LEAF_ISSUE;
               else if (n_ff == '0) state_in = btcp_pkg::ST_DONE;
               else                 state_in = btcp_pkg::ST_FOLD_LOAD;
            end
         end
         btcp_pkg::ST_FOLD_LOAD: state_in = btcp_pkg::ST_FOLD_RUN;
         btcp_pkg::ST_FOLD_RUN: begin
            if (idx_ff == level_ff) state_in = btcp_pkg::ST_FOLD_DRAIN;
         end
         btcp_pkg::ST_FOLD_DRAIN: begin
            // wait until every node of this level sits in the RAM
            if (drained) begin
               state_in = (level_ff == AW'(1)) ? btcp_pkg::ST_DONE : btcp_pkg::ST_FOLD_LOAD;
            end
         end
         btcp_pkg::ST_DONE: begin
            if (rsp_free) state_in = btcp_pkg::ST_IDLE;
         end
         default: state_in = btcp_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      req_ch.ready = 1'b0;
      mac_req      = '0;
      mac_tag_in   = '0;
      ram_re       = 1'b0;
      ram_raddr    = '0;
      unique case (state_ff)
         btcp_pkg::ST_IDLE: req_ch.ready = 1'b1;
         btcp_pkg::ST_LEAF_ISSUE: begin
            // first leaf starts from the spot price, the rest step by u^2
            mac_req.valid = 1'b1;
            mac_req.op    = btcp_pkg::MAC_LEAF;
            mac_req.a0    = (idx_ff == '0) ? spot_ff : asset_ff;
            mac_req.b0    = (idx_ff == '0) ? lowest_factor_ff : up_squared_ff;
            mac_tag_in    = idx_ff;
         end
         btcp_pkg::ST_FOLD_LOAD: begin
            ram_re    = 1'b1;
            ram_raddr = '0;
         end
         btcp_pkg::ST_FOLD_RUN, btcp_pkg::ST_FOLD_DRAIN: begin
            ram_re    = (state_ff == btcp_pkg::ST_FOLD_RUN);
            ram_raddr = idx_ff;
            // C[j+1] arrives from the RAM, C[j] is held from the previous read
            mac_req.valid = rd_valid_ff && (rd_addr_ff != '0);
            mac_req.op    = btcp_pkg::MAC_FOLD;
            mac_req.a0    = disc_up_prob_ff;
            mac_req.b0    = ram_rdata;
            mac_req.a1    = disc_down_prob_ff;
            mac_req.b1    = lower_ff;
            mac_tag_in    = rd_addr_ff - AW'(1);
         end
         default: ;
      endcase
   end

   // Every RAM write comes back from the multiply-add unit, tagged with its address
   assign ram_we    = mac_res.valid;
   assign ram_wdata = (state_ff == btcp_pkg::ST_LEAF_WAIT) ? leaf_value : mac_res.value;

   // ---------------------------------------------------------------- register updates
   always_comb begin
      spot_in      = spot_ff;
      strike_in    = strike_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      level_in     = level_ff;
      asset_in     = asset_ff;
      asset_sat_in = asset_sat_ff;
      sat_in       = sat_ff;
      lower_in     = rd_valid_ff ? ram_rdata : lower_ff;
      rd_valid_in  = ram_re;
      rd_addr_in   = ram_raddr;
      root_in      = (ram_we && mac_tag_out == '0) ? ram_wdata : root_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_value_in = rsp_value_ff;
      rsp_sat_in   = rsp_sat_ff;

      unique case (state_ff)
         btcp_pkg::ST_IDLE: begin
            if (req_accept) begin
               spot_in      = req_ch.spot_price;
               strike_in    = req_ch.strike_price;
               n_in         = steps_clamped;
               level_in     = steps_clamped;
               idx_in       = '0;
               asset_sat_in = 1'b0;
               sat_in       = 1'b0;
            end
         end
         btcp_pkg::ST_LEAF_WAIT: begin
            if (mac_res.valid) begin
               asset_in     = mac_res.value;
               asset_sat_in = leaf_sat;
               sat_in       = sat_ff | leaf_sat;
               if (idx_ff != n_ff) idx_in = idx_ff + AW'(1);
            end
         end
         btcp_pkg::ST_FOLD_LOAD: idx_in = AW'(1);
         btcp_pkg::ST_FOLD_RUN: begin
            if (mac_res.valid) sat_in = sat_ff | mac_res.sat;
            if (idx_ff != level_ff) idx_in = idx_ff + AW'(1);
         end
         btcp_pkg::ST_FOLD_DRAIN: begin
            if (mac_res.valid) sat_in = sat_ff | mac_res.sat;
            if (drained) level_in = level_ff - AW'(1);
         end
         btcp_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = root_ff;
               rsp_sat_in   = sat_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= btcp_pkg::ST_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      spot_ff      <= spot_in;
      strike_ff    <= strike_in;
      n_ff         <= n_in;
      idx_ff       <= idx_in;
      level_ff     <= level_in;
      asset_ff     <= asset_in;
      asset_sat_ff <= asset_sat_in;
      sat_ff       <= sat_in;
      lower_ff     <= lower_in;
      rd_addr_ff   <= rd_addr_in;
      root_ff      <= root_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.option_value = rsp_value_ff;
   assign rsp_ch.saturated    = rsp_sat_ff;

   // ---------------------------------------------------------------- units
   btcp_mac #(
      .TAG_W (AW)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .req_in  (mac_req),
      .tag_in  (mac_tag_in),
      .res_out (mac_res),
      .tag_out (mac_tag_out),
      .busy    (mac_busy)
   );

   btcp_ram #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock      (clock),
      .write_en   (ram_we),
      .write_addr (mac_tag_out),
      .write_data (ram_wdata),
      .read_en    (ram_re),
      .read_addr  (ram_raddr),
      .read_data  (ram_rdata)
   );

`ifndef SYNTHESIS
   a_accept_starts_leaves: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == btcp_pkg::ST_LEAF_ISSUE)
      else $error("accepted word did not start the leaf phase");

   a_write_in_tree: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> mac_tag_out <= n_ff)
      else $error("node write beyond the tree");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == btcp_pkg::ST_DONE))
      else $error("result posted outside the done state");

   a_idle_unit_empty: assert property (@(posedge clock) disable iff (reset)
      state_ff == btcp_pkg::ST_IDLE |-> !mac_busy && !rd_valid_ff)
      else $error("work still in flight while idle");
`endif

endmodule

>>> rtl/btcp_mac.sv
// ----------------------------------------------------------------------------
// btcp_mac: shared two-stage multiply-add unit
// Stage one forms two 32x32 products; stage two adds, rounds to nearest,
// shifts to Q16.16 and saturates. One operation per cycle.
// ----------------------------------------------------------------------------
module btcp_mac #(
   parameter int TAG_W = 11
) (
   input  logic                        clock,
   input  logic                        reset,
   input  btcp_pkg::mac_req_type       req_in,
   input  logic [TAG_W-1:0]            tag_in,
   output btcp_pkg::mac_res_type       res_out,
   output logic [TAG_W-1:0]            tag_out,
   output logic                        busy
);

   localparam int PW = 2 * btcp_pkg::DATA_W;
   localparam int SW = PW + 2;

   logic                   v1_ff;
   btcp_pkg::mac_op_type   op1_ff;
   logic [PW-1:0]          p0_ff;
   logic [PW-1:0]          p1_ff;
   logic [TAG_W-1:0]       tag1_ff;

   logic                   v2_ff;
   logic                   sat2_ff;
   logic [btcp_pkg::DATA_W-1:0] value2_ff;
   logic [TAG_W-1:0]       tag2_ff;

   logic [SW-1:0]          sum;
   logic [SW-31:0]         quot;
   logic                   sat_in;
   logic [btcp_pkg::DATA_W-1:0] value_in;

   // Stage one: products
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= req_in.valid;
      end
      op1_ff  <= req_in.op;
      p0_ff   <= PW'(req_in.a0) * PW'(req_in.b0);
      p1_ff   <= PW'(req_in.a1) * PW'(req_in.b1);
      tag1_ff <= tag_in;
   end

   // Stage two: add, round, shift, clamp
   always_comb begin
      if (op1_ff == btcp_pkg::MAC_LEAF) begin
         sum  = SW'(p0_ff) + SW'(p1_ff) + (SW'(1) << 29);
         quot = sum[SW-1:30];
      end else begin
         sum  = SW'(p0_ff) + SW'(p1_ff) + (SW'(1) << 30);
         quot = {1'b0, sum[SW-1:31]};
      end
      sat_in   = |quot[SW-31:btcp_pkg::DATA_W];
      value_in = sat_in ? btcp_pkg::SAT_VALUE : quot[btcp_pkg::DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      sat2_ff   <= sat_in;
      value2_ff <= value_in;
      tag2_ff   <= tag1_ff;
   end

   assign res_out.valid = v2_ff;
   assign res_out.sat   = sat2_ff;
   assign res_out.value = value2_ff;
   assign tag_out       = tag2_ff;
   assign busy          = v1_ff | v2_ff;

endmodule

>>> rtl/btcp_ram.sv
// ----------------------------------------------------------------------------
// btcp_ram: node value store
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module btcp_ram #(
   parameter int DEPTH = 1025,
   parameter int AW    = 11
) (
   input  logic                        clock,
   input  logic                        write_en,
   input  logic [AW-1:0]               write_addr,
   input  logic [btcp_pkg::DATA_W-1:0] write_data,
   input  logic                        read_en,
   input  logic [AW-1:0]               read_addr,
   output logic [btcp_pkg::DATA_W-1:0] read_data
);

   logic [btcp_pkg::DATA_W-1:0] mem [DEPTH];
   logic [btcp_pkg::DATA_W-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_en) begin
         mem[write_addr] <= write_data;
      end
      if (read_en) begin
         read_data_ff <= mem[read_addr];
      end
   end

   assign read_data = read_data_ff;

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for binomial_tree_call_pricer
// Drives spot/strike request words through a queue-fed driver, prices each
// accepted word with an independent fixed-point tree model and checks every
// response word field by field, across many CSR settings and random stalls.
// ----------------------------------------------------------------------------
module testbench;

   localparam int DATA_W     = btcp_pkg::DATA_W;
   localparam int STEPS_W    = btcp_pkg::STEPS_W;
   localparam int CSR_IDX_W  = btcp_pkg::CSR_IDX_W;
   localparam int TREE_DEPTH = btcp_pkg::MAX_STEPS_DEF;

   // Indexes past the last CSR; writes there must be dropped by the block.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_FIRST = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LAST  = 3'd7;

   localparam logic [DATA_W-1:0] Q30_ONE   = 32'h4000_0000;
   localparam logic [DATA_W-1:0] Q31_ONE   = 32'h8000_0000;
   localparam logic [DATA_W-1:0] ALL_ONES  = 32'hFFFF_FFFF;
   localparam logic [DATA_W-1:0] PRICE_MIN = 32'h0001_0000;  // 1.0 in Q16.16
   localparam logic [DATA_W-1:0] PRICE_MAX = 32'h03E8_0000;  // 1000.0 in Q16.16

   localparam int RANDOM_PHASES    = 10;
   localparam int WORDS_PER_PHASE  = 25;
   localparam int SETTLE_CYCLES    = 50;
   localparam longint RUN_LIMIT    = 80_000_000;

   typedef struct packed {
      logic [DATA_W-1:0] spot;
      logic [DATA_W-1:0] strike;
      logic              drain_first;   // hold this word until all prices are back
   } quote_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              sat;
   } call_price_type;

   logic                 clock;
   logic                 reset;
   logic                 csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0]    csr_write_data;

   btcp_req_if req_ch ();
   btcp_rsp_if rsp_ch ();

   binomial_tree_call_pricer #(
      .MAX_STEPS (TREE_DEPTH)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   // Shadow copy of the CSRs, updated as each write is issued.
   logic [STEPS_W-1:0] cfg_steps;
   logic [DATA_W-1:0]  cfg_up_sq;
   logic [DATA_W-1:0]  cfg_lowest;
   logic [DATA_W-1:0]  cfg_pus;
   logic [DATA_W-1:0]  cfg_pds;

   logic [DATA_W-1:0]  tree_nodes [0:TREE_DEPTH];

   quote_type      quote_q [$];    // request words not yet offered
   call_price_type price_q [$];    // prices of accepted words, oldest first

   bit req_steady;              // no sender gaps in this phase
   bit rsp_steady;              // no receiver stalls in this phase
   int req_gap;
   int rsp_stall;

   int error_count;
   int words_priced;
   int prices_checked;
   int sat_prices;
   int settings_loaded;

   always #5 clock = ~clock;

   // -------------------------------------------------------------------------
   // Price model
   // -------------------------------------------------------------------------

   // Q16.16 times Q2.30, round to nearest, clamp; bit 32 flags the clamp.
   function automatic logic [DATA_W:0] scale_q30(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] f);
      logic [63:0] p;
      p = 64'(a) * 64'(f) + (64'd1 << 29);
      p = p >> 30;
      if (p[63:DATA_W] != '0)
         return {1'b1, btcp_pkg::SAT_VALUE};
      return {1'b0, p[DATA_W-1:0]};
   endfunction

   // pus*upper + pds*lower back to Q16.16 with rounding; keep all 66 bits.
   function automatic logic [DATA_W:0] fold_pair(input logic [DATA_W-1:0] upper,
                                                 input logic [DATA_W-1:0] lower);
      logic [65:0] s;
      s = 66'(cfg_pus) * 66'(upper) + 66'(cfg_pds) * 66'(lower) + (66'd1 << 30);
      s = s >> 31;
      if (s[65:DATA_W] != '0)
         return {1'b1, btcp_pkg::SAT_VALUE};
      return {1'b0, s[DATA_W-1:0]};
   endfunction

   function automatic call_price_type price_call(input logic [DATA_W-1:0] spot,
                                                 input logic [DATA_W-1:0] strike);
      call_price_type    res;
      logic [DATA_W-1:0] asset;
      logic              asset_sat;
      logic              node_sat;
      int                n;
      res.sat = 1'b0;
      // Clamp an oversized step count to the tree depth.
      n = (int'(cfg_steps) > TREE_DEPTH) ? TREE_DEPTH : int'(cfg_steps);
      {asset_sat, asset} = scale_q30(spot, cfg_lowest);
      for (int i = 0; i <= n; i++) begin
         if (i > 0) begin
            // Once the asset price clamps, every higher leaf stays clamped.
            if (asset_sat)
               asset = btcp_pkg::SAT_VALUE;
            else
               {asset_sat, asset} = scale_q30(asset, cfg_up_sq);
         end
         if (asset_sat) begin
            tree_nodes[i] = btcp_pkg::SAT_VALUE;
            res.sat       = 1'b1;
         end else begin
            tree_nodes[i] = (asset > strike) ? asset - strike : '0;
         end
      end
      for (int lvl = n; lvl > 0; lvl--) begin
         for (int j = 0; j < lvl; j++) begin
            {node_sat, tree_nodes[j]} = fold_pair(tree_nodes[j+1], tree_nodes[j]);
            res.sat |= node_sat;
         end
      end
      res.value = tree_nodes[0];
      return res;
   endfunction

   // Mostly back-to-back, some short gaps, a few long ones.
   function automatic int pick_gap(input bit steady);
      int roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // -------------------------------------------------------------------------
   // Request driver: price each accepted word, then offer the next one
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      logic next_valid;
      quote_type q;
      if (reset) begin
         req_ch.valid        <= 1'b0;
         req_ch.spot_price   <= '0;
         req_ch.strike_price <= '0;
         req_gap = 0;
      end else begin
         next_valid = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            price_q = {price_q, price_call(req_ch.spot_price, req_ch.strike_price)};
            words_priced++;
            req_gap = pick_gap(req_steady);
         end
         if (req_ch.valid && !req_ch.ready) begin
            // Hold the word and its payload until the block takes it.
            next_valid = 1'b1;
         end else if (req_gap > 0) begin
            req_gap--;
         end else if (quote_q.size() > 0 &&
                      !(quote_q[0].drain_first && price_q.size() > 0)) begin
            q = quote_q.pop_front();
            req_ch.spot_price   <= q.spot;
            req_ch.strike_price <= q.strike;
            next_valid = 1'b1;
         end
         req_ch.valid <= next_valid;
      end
   end

   // -------------------------------------------------------------------------
   // Response monitor: compare each accepted word with the oldest price
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      call_price_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (price_q.size() == 0) begin
               $display("%0t: response word with no price pending: value %h sat %b",
                        $time, rsp_ch.option_value, rsp_ch.saturated);
               error_count++;
            end else begin
               want = price_q.pop_front();
               prices_checked++;
               if (want.sat)
                  sat_prices++;
               if (rsp_ch.option_value !== want.value) begin
                  $display("%0t: option_value mismatch: expected %h, actual %h",
                           $time, want.value, rsp_ch.option_value);
                  error_count++;
               end
               if (rsp_ch.saturated !== want.sat) begin
                  $display("%0t: saturated mismatch: expected %b, actual %b",
                           $time, want.sat, rsp_ch.saturated);
                  error_count++;
               end
            end
            rsp_stall = pick_gap(rsp_steady);
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_ch.ready <= (rsp_stall == 0);
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------

   // Write one CSR over a single edge and mirror it into the shadow copy.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] data);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      case (idx)
         btcp_pkg::CSR_NUM_STEPS:      cfg_steps  = data[STEPS_W-1:0];
         btcp_pkg::CSR_UP_SQUARED:     cfg_up_sq  = data;
         btcp_pkg::CSR_LOWEST_FACTOR:  cfg_lowest = data;
         btcp_pkg::CSR_DISC_UP_PROB:   cfg_pus    = data;
         btcp_pkg::CSR_DISC_DOWN_PROB: cfg_pds    = data;
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic load_settings(input logic [DATA_W-1:0] steps_word,
                                input logic [DATA_W-1:0] up_sq,
                                input logic [DATA_W-1:0] lowest,
                                input logic [DATA_W-1:0] pus,
                                input logic [DATA_W-1:0] pds);
      write_reg(btcp_pkg::CSR_NUM_STEPS, steps_word);
      write_reg(btcp_pkg::CSR_UP_SQUARED, up_sq);
      write_reg(btcp_pkg::CSR_LOWEST_FACTOR, lowest);
      write_reg(btcp_pkg::CSR_DISC_UP_PROB, pus);
      write_reg(btcp_pkg::CSR_DISC_DOWN_PROB, pds);
      settings_loaded++;
   endtask

   task automatic queue_quote(input logic [DATA_W-1:0] spot, input logic [DATA_W-1:0] strike,
                              input logic drain_first);
      quote_type q;
      q.spot        = spot;
      q.strike      = strike;
      q.drain_first = drain_first;
      quote_q = {quote_q, q};
   endtask

   // Block until every word is sent and every price is back; sample on the
   // falling edge so the check never races the clocked blocks.
   task automatic wait_idle();
      @(negedge clock);
      while (quote_q.size() != 0 || price_q.size() != 0 || req_ch.valid)
         @(negedge clock);
   endtask

   // Step count with junk above the field, to check the block drops it.
   function automatic logic [DATA_W-1:0] steps_word(input int n);
      logic [DATA_W-1:0] w;
      w = $urandom();
      w[STEPS_W-1:0] = n[STEPS_W-1:0];
      return w;
   endfunction

   function automatic logic [DATA_W-1:0] pick_prob();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80)
         return $urandom_range(32'h3C00_0000, 32'h4100_0000);
      if (roll < 95)
         return $urandom_range(0, Q31_ONE);
      return $urandom();
   endfunction

   initial begin
      int               n;
      int               roll;
      logic [DATA_W-1:0] spot;
      logic [DATA_W-1:0] strike;

      clock          = 1'b0;
      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_write_data = '0;
      req_steady     = 1'b0;
      rsp_steady     = 1'b0;
      error_count    = 0;
      words_priced   = 0;
      prices_checked = 0;
      sat_prices     = 0;
      settings_loaded = 0;
      // Shadow the reset values of the CSRs.
      cfg_steps  = btcp_pkg::NUM_STEPS_RST;
      cfg_up_sq  = btcp_pkg::ONE_Q30_RST;
      cfg_lowest = btcp_pkg::ONE_Q30_RST;
      cfg_pus    = btcp_pkg::HALF_Q31_RST;
      cfg_pds    = btcp_pkg::HALF_Q31_RST;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings, field extremes and a plain in/at the money pair.
      queue_quote('0, '0, 1'b0);
      queue_quote(ALL_ONES, '0, 1'b0);
      queue_quote('0, ALL_ONES, 1'b0);
      queue_quote(ALL_ONES, ALL_ONES, 1'b0);
      queue_quote(32'h0064_0000, 32'h005A_0000, 1'b0);
      queue_quote(32'h0032_8000, 32'h0032_8000, 1'b1);
      wait_idle();

      // Zero steps: the root is the single lowest leaf.
      load_settings(steps_word(0), 32'h4400_0000, 32'h3C00_0000, 32'h3E00_0000, 32'h3F00_0000);
      queue_quote(32'h0064_0000, 32'h0050_0000, 1'b0);
      queue_quote(32'h0064_0000, 32'h0070_0000, 1'b0);
      wait_idle();

      // Largest up factor with probabilities of one: drive leaf prices
      // into the clamp and force nodes over the top.
      load_settings(steps_word(3), ALL_ONES, Q30_ONE, Q31_ONE, Q31_ONE);
      queue_quote(PRICE_MIN, '0, 1'b0);
      queue_quote(32'h1000_0000, PRICE_MIN, 1'b0);
      queue_quote(32'h8000_0000, '0, 1'b0);
      wait_idle();

      // Probabilities above one, zero up factor, largest lowest factor.
      load_settings(steps_word(2), '0, ALL_ONES, ALL_ONES, ALL_ONES);
      queue_quote(32'h4000_0000, '0, 1'b0);
      queue_quote(PRICE_MIN, 32'h0000_8000, 1'b0);
      wait_idle();

      // Zero lowest factor and probabilities, up factor of one; then hit the unused indexes, which must be dropped.
      load_settings(steps_word(5), Q30_ONE, '0, '0, '0);
      for (int k = CSR_SPARE_FIRST; k <= CSR_SPARE_LAST; k++)
         write_reg(k[CSR_IDX_W-1:0], ALL_ONES);
      queue_quote(32'h0064_0000, '0, 1'b0);
      wait_idle();

      // Oversized step count: clamps to the full tree depth. One word only,
      // this is by far the slowest price of the run.
      load_settings({{(DATA_W-STEPS_W){1'b0}}, {STEPS_W{1'b1}}},
                    32'h4010_0000, 32'h3000_0000, 32'h3FE0_0000, 32'h3FF0_0000);
      queue_quote(32'h0064_0000, 32'h0064_0000, 1'b0);
      wait_idle();

      // Random phases: fresh settings each time, mostly shallow trees and
      // realistic factors, with some full-range noise mixed in.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         roll = $urandom_range(0, 99);
         if (roll < 70)
            n = $urandom_range(0, 12);
         else if (roll < 95)
            n = $urandom_range(13, 40);
         else
            n = $urandom_range(41, 80);
         load_settings(steps_word(n),
                       ($urandom_range(0, 99) < 85) ?
                          Q30_ONE + $urandom_range(0, 32'h0200_0000) : $urandom(),
                       ($urandom_range(0, 99) < 85) ?
                          $urandom_range(32'h3400_0000, Q30_ONE) : $urandom(),
                       pick_prob(), pick_prob());
         req_steady = ($urandom_range(0, 3) == 0);
         rsp_steady = ($urandom_range(0, 3) == 0);
         for (int w = 0; w < WORDS_PER_PHASE; w++) begin
            if ($urandom_range(0, 99) < 85) begin
               // Strike within a band around spot.
               spot   = $urandom_range(PRICE_MIN, PRICE_MAX);
               strike = spot - (spot >> 2) + $urandom_range(0, spot >> 1);
            end else begin
               spot   = $urandom();
               strike = $urandom();
            end
            queue_quote(spot, strike, ($urandom_range(0, 99) < 3));
         end
         wait_idle();
      end

      // Drain: let any stray response word show up before closing.
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Priced %0d words over %0d CSR settings; %0d prices checked, %0d saturated",
               words_priced, settings_loaded + 1, prices_checked, sat_prices);
      $display("Tree depths ranged from zero steps to the clamped maximum of %0d", TREE_DEPTH);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, deep tree included.
   initial begin
      #(RUN_LIMIT);
      $display("Timeout with %0d prices outstanding", price_q.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
